### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define WSOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off while reset is high.
`define WSOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Condition that must hold in the cycle after reset is seen.
`define WSOL_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

### hw/rtl/wsol_pkg.sv
// Shared types and constants of the window stacking order list.
package wsol_pkg;

  localparam int ID_W        = 7;
  localparam int ENTRIES_DEF = 128;

  // Operation codes on the op input
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_RAISE  = 2'd1,
    OP_LOWER  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  // What a token does as it travels down the cell chain
  typedef enum logic [1:0] {
    K_FRONT  = 2'd0,
    K_BACK   = 2'd1,
    K_REMOVE = 2'd2
  } wsol_kind_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WAVE = 2'd1,
    ST_FIN  = 2'd2
  } wsol_state_t;

  // Token handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic              vld;
    wsol_kind_t        kind;
    logic              pull;    // shifting entries toward the front
    logic              done;    // list update finished, token just drains
    logic [ID_W-1:0]   target;  // id the transaction acts on
    logic [ID_W-1:0]   carry;   // id being pushed toward the back
    logic              bk_set;  // back id changes
    logic [ID_W-1:0]   bk_val;  // new back id
  } wsol_tok_t;

  // Contents of one slot as seen by its neighbors
  typedef struct packed {
    logic            occ;
    logic [ID_W-1:0] wid;
  } wsol_slot_t;

endpackage

### hw/rtl/wsol_cell.sv
// One slot of the stacking order chain: holds one id and forwards the token.
module wsol_cell import wsol_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  wsol_tok_t  tok_in,
  output wsol_tok_t  tok_out,
  input  wsol_slot_t l_slot,
  input  wsol_slot_t r_slot,
  output wsol_slot_t slot
);

  logic            occ;
  logic            occ_next;
  logic [ID_W-1:0] wid;
  logic [ID_W-1:0] wid_next;
  wsol_tok_t       tok_next;
  logic            hit;

  assign slot = '{occ: occ, wid: wid};
  assign hit  = occ && (wid == tok_in.target);

  // Slot update and token forwarding
  always_comb begin
    occ_next = occ;
    wid_next = wid;
    tok_next = tok_in;
    if (tok_in.vld && !tok_in.done) begin
      case (tok_in.kind)
        K_FRONT: begin
          // push toward the back until the old place or a free slot
          wid_next = tok_in.carry;
          if (!occ || hit) begin
            occ_next      = 1'b1;
            tok_next.done = 1'b1;
            if (!r_slot.occ) begin
              tok_next.bk_set = 1'b1;
              tok_next.bk_val = tok_in.carry;
            end
          end else begin
            tok_next.carry = wid;
          end
        end
        K_BACK, K_REMOVE: begin
          // from the target on, pull each entry one slot to the front
          if (tok_in.pull || hit) begin
            if (r_slot.occ) begin
              wid_next      = r_slot.wid;
              tok_next.pull = 1'b1;
            end else if (tok_in.kind == K_BACK) begin
              wid_next        = tok_in.target;
              tok_next.done   = 1'b1;
              tok_next.bk_set = 1'b1;
              tok_next.bk_val = tok_in.target;
            end else begin
              occ_next        = 1'b0;
              tok_next.done   = 1'b1;
              tok_next.bk_set = 1'b1;
              tok_next.bk_val = l_slot.wid;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Occupancy and token registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ     <= 1'b0;
      tok_out <= '0;
    end else begin
      occ     <= occ_next;
      tok_out <= tok_next;
    end
  end

  // Slot id
  always_ff @(posedge clk) begin
    wid <= wid_next;
  end

endmodule

### hw/rtl/window_stacking_order_list.sv
// Window stacking order list: sequencer, presence bits and the chain of slot cells.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_stall   | op, window_id
//   out     | out_valid / out_stall | status, front_id, back_id, list_empty
//
// A create of an in-range id, or a raise, lower or remove of a present id, sends a
// token down the cell chain one cell per cycle, DEPTH being min(ENTRIES, 128): the
// token is registered at the chain head and in each cell, and the result is then
// loaded into the output register from the finish state. An item on an absent or
// out-of-range id skips the chain and goes straight to the finish state.
// Reset clears all control state; no clearing pass follows.
// Input is taken only while the sequencer is idle; a stalled result waits in the
// output register while the next item runs, and that item then waits to finish.
module window_stacking_order_list import wsol_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      op,
  input  logic [ID_W-1:0] window_id,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            status,
  output logic [ID_W-1:0] front_id,
  output logic [ID_W-1:0] back_id,
  output logic            list_empty
);

  // Ids above DEPTH - 1 never reach the chain
  localparam int DEPTH = (ENTRIES < (1 << ID_W)) ? ENTRIES : (1 << ID_W);
  localparam int PW    = $clog2(DEPTH);
  localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(DEPTH - 1);

  wsol_state_t     state;
  wsol_state_t     state_next;
  logic [DEPTH-1:0] present;
  logic [ID_W-1:0] back_reg;
  logic            req_status;
  wsol_tok_t       tok_head;
  wsol_tok_t       tok_launch;
  wsol_tok_t       tok_chain [DEPTH+1];
  wsol_slot_t      slots [DEPTH];

  logic            in_acc;
  logic            out_acc;
  logic            load_out;
  logic            in_range;
  logic            here;
  logic            run;
  wsol_kind_t      kind;
  logic [PW-1:0]   idx;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign idx     = window_id[PW-1:0];
  assign in_range = (window_id <= ID_LIMIT);
  assign here    = in_range && present[idx];

  // Decode the request into a chain token kind
  always_comb begin
    run  = 1'b0;
    kind = K_FRONT;
    case (op_t'(op))
      OP_CREATE: begin
        run  = in_range;
        kind = K_FRONT;
      end
      OP_RAISE: begin
        run  = here;
        kind = K_FRONT;
      end
      OP_LOWER: begin
        run  = here;
        kind = K_BACK;
      end
      OP_REMOVE: begin
        run  = here;
        kind = K_REMOVE;
      end
      default: ;
    endcase
  end

  // Token launched for a transaction that walks the chain
  always_comb begin
    tok_launch = '0;
    if (in_acc && run) begin
      tok_launch.vld    = 1'b1;
      tok_launch.kind   = kind;
      tok_launch.target = window_id;
      tok_launch.carry  = window_id;
    end
  end

  assign tok_chain[0] = tok_head;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc) state_next = run ? ST_WAVE : ST_FIN;
      ST_WAVE: if (tok_chain[DEPTH].vld) state_next = ST_FIN;
      ST_FIN:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_WAVE: ;
      ST_FIN:  load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      present   <= '0;
      back_reg  <= '0;
      out_valid <= 1'b0;
      tok_head  <= '0;
    end else begin
      state    <= state_next;
      tok_head <= tok_launch;

      if (in_acc && op_t'(op) == OP_CREATE && in_range) present[idx] <= 1'b1;
      if (in_acc && op_t'(op) == OP_REMOVE && here)     present[idx] <= 1'b0;

      if (tok_chain[DEPTH].vld && tok_chain[DEPTH].bk_set) back_reg <= tok_chain[DEPTH].bk_val;

      if (load_out)     out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
    end
  end

  // Request status and result payload
  always_ff @(posedge clk) begin
    if (in_acc) req_status <= !run;
    if (load_out) begin
      status     <= req_status;
      list_empty <= !slots[0].occ;
      front_id   <= slots[0].occ ? slots[0].wid : '0;
      back_id    <= slots[0].occ ? back_reg : '0;
    end
  end

  // Chain of slot cells, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    wsol_slot_t l_slot;
    wsol_slot_t r_slot;

    if (i == 0) begin : g_first
      assign l_slot = '0;
    end else begin : g_mid_l
      assign l_slot = slots[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_slot = '0;
    end else begin : g_mid_r
      assign r_slot = slots[i+1];
    end

    wsol_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .l_slot  (l_slot),
      .r_slot  (r_slot),
      .slot    (slots[i])
    );
  end

endmodule

### hw/rtl/wsol_chk.sv
// Port-level checker for the window stacking order list, bound to the top level.
`include "assert_macros.svh"

module wsol_chk import wsol_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input logic            status,
  input logic [ID_W-1:0] front_id,
  input logic [ID_W-1:0] back_id,
  input logic            list_empty
);

  // a stalled result keeps its payload
  `WSOL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(front_id) && $stable(back_id) && $stable(list_empty), "stalled result changed")

  // one transaction at a time: busy right after taking an item
  `WSOL_ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall, "input taken while busy")

  // an empty list reports zero ids
  `WSOL_ASSERT_NOW(a_empty_ids, out_valid && list_empty, front_id == '0 && back_id == '0, "empty list with nonzero ids")

  // reset leaves the block idle with nothing to deliver
  `WSOL_ASSERT_AFTER_RST(a_rst_idle, !out_valid && !in_stall, "not idle after reset")

endmodule

bind window_stacking_order_list wsol_chk u_wsol_chk (.*);

### bench/window_stacking_order_list_tb.sv
// Self-checking testbench for the window stacking order list: directed table plus random ops.
`timescale 1ns / 1ps

module window_stacking_order_list_tb;
  import wsol_pkg::*;

  localparam int NUM_IDS      = ENTRIES_DEF;
  localparam int RAND_ITEMS   = 950;
  localparam int DRAIN_CYCLES = NUM_IDS + 20;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] front;
    logic [ID_W-1:0] back;
    logic            empty;
  } order_rsp_t;

  typedef struct packed {
    op_t             opc;
    logic [ID_W-1:0] id;
    logic            typed;
    order_rsp_t      rsp;
  } dir_row_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  logic [1:0]      op;
  logic [ID_W-1:0] window_id;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            status;
  logic [ID_W-1:0] front_id;
  logic [ID_W-1:0] back_id;
  logic            list_empty;

  window_stacking_order_list dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .window_id  (window_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .front_id   (front_id),
    .back_id    (back_id),
    .list_empty (list_empty)
  );

  // Shadow copy of the stacking order
  logic [ID_W-1:0]    link_back [NUM_IDS];
  logic [ID_W-1:0]    link_front[NUM_IDS];
  logic [NUM_IDS-1:0] in_list;
  logic [ID_W-1:0]    top_id;
  logic [ID_W-1:0]    bottom_id;
  logic               none_left;

  order_rsp_t rsp_q[$];
  dir_row_t   dir_rows[$];
  int         errors   = 0;
  int         rsp_seen = 0;
  int         items_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Take a present id out of a list of two or more
  function automatic void detach(logic [ID_W-1:0] id);
    if (id == top_id) begin
      top_id = link_back[id];
    end else if (id == bottom_id) begin
      bottom_id = link_front[id];
    end else begin
      link_back[link_front[id]] = link_back[id];
      link_front[link_back[id]] = link_front[id];
    end
  endfunction

  function automatic void attach_top(logic [ID_W-1:0] id);
    if (none_left) begin
      bottom_id = id;
      none_left = 1'b0;
    end else begin
      link_back[id]      = top_id;
      link_front[top_id] = id;
    end
    top_id = id;
  endfunction

  // Called only with a non-empty list
  function automatic void attach_bottom(logic [ID_W-1:0] id);
    link_front[id]        = bottom_id;
    link_back[bottom_id]  = id;
    bottom_id             = id;
  endfunction

  // Apply one operation to the shadow list and return the response it should give
  function automatic order_rsp_t apply_op(op_t opc, logic [ID_W-1:0] id);
    order_rsp_t r;
    logic       here;
    here     = in_list[id];
    r.status = 1'b0;
    if (opc == OP_CREATE && !here) begin
      in_list[id] = 1'b1;
      attach_top(id);
    end else if (!here) begin
      r.status = 1'b1;
    end else if (opc == OP_CREATE || opc == OP_RAISE) begin
      if (id != top_id) begin
        detach(id);
        attach_top(id);
      end
    end else if (opc == OP_LOWER) begin
      if (id != bottom_id) begin
        detach(id);
        attach_bottom(id);
      end
    end else begin
      if (id == top_id && id == bottom_id) begin
        top_id    = '0;
        bottom_id = '0;
        none_left = 1'b1;
      end else begin
        detach(id);
      end
      in_list[id] = 1'b0;
    end
    r.front = none_left ? '0 : top_id;
    r.back  = none_left ? '0 : bottom_id;
    r.empty = none_left;
    return r;
  endfunction

  // Mostly a present id when there is one, otherwise any id
  function automatic logic [ID_W-1:0] pick_id(int pct_present);
    int start;
    start = $urandom_range(0, NUM_IDS - 1);
    if (in_list != '0 && $urandom_range(0, 99) < pct_present) begin
      for (int k = 0; k < NUM_IDS; k++) begin
        if (in_list[(start + k) % NUM_IDS]) return ID_W'((start + k) % NUM_IDS);
      end
    end
    return ID_W'(start);
  endfunction

  task automatic add_row(op_t opc, int id, bit typed, bit st, int fr, int bk, bit em);
    dir_row_t d;
    d.opc        = opc;
    d.id         = ID_W'(id);
    d.typed      = typed;
    d.rsp.status = st;
    d.rsp.front  = ID_W'(fr);
    d.rsp.back   = ID_W'(bk);
    d.rsp.empty  = em;
    dir_rows.push_back(d);
  endtask

  // Offer one transaction, hold it until taken, then record what it should return
  task automatic send(op_t opc, logic [ID_W-1:0] id, logic typed, order_rsp_t typed_rsp);
    order_rsp_t pred;
    in_valid  <= 1'b1;
    op        <= opc;
    window_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_op(opc, id);
    rsp_q.push_back(typed ? typed_rsp : pred);
    items_sent++;
    // random gaps, none in the quiet stretch
    if (!(items_sent > 400 && items_sent < 600) && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stimulus
  initial begin
    op_t             opc;
    logic [ID_W-1:0] id;
    int              roll;
    int              p_create;
    int              p_raise;
    int              p_lower;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_CREATE;
    window_id  <= '0;
    in_list    = '0;
    top_id     = '0;
    bottom_id  = '0;
    none_left  = 1'b1;
    items_sent = 0;

    // Empty list, absent ids, single entry, front/back no-ops, create of present id,
    // middle/front/back moves and removals, removal of the only entry
    add_row(OP_REMOVE,   0, 1, 1,   0, 0, 1);
    add_row(OP_RAISE,  127, 1, 1,   0, 0, 1);
    add_row(OP_LOWER,   85, 1, 1,   0, 0, 1);
    add_row(OP_CREATE,   0, 1, 0,   0, 0, 0);
    add_row(OP_LOWER,    0, 1, 0,   0, 0, 0);
    add_row(OP_CREATE, 127, 1, 0, 127, 0, 0);
    add_row(OP_CREATE, 127, 1, 0, 127, 0, 0);
    add_row(OP_RAISE,  127, 1, 0, 127, 0, 0);
    add_row(OP_LOWER,    0, 1, 0, 127, 0, 0);
    add_row(OP_CREATE,  85, 1, 0,  85, 0, 0);
    add_row(OP_CREATE,  42, 1, 0,  42, 0, 0);
    add_row(OP_RAISE,  127, 0, 0,   0, 0, 0);
    add_row(OP_LOWER,   42, 0, 0,   0, 0, 0);
    add_row(OP_RAISE,   42, 0, 0,   0, 0, 0);
    add_row(OP_LOWER,   42, 0, 0,   0, 0, 0);
    add_row(OP_CREATE,  85, 0, 0,   0, 0, 0);
    add_row(OP_REMOVE,  99, 0, 0,   0, 0, 0);
    add_row(OP_REMOVE,   0, 0, 0,   0, 0, 0);
    add_row(OP_REMOVE,  85, 0, 0,   0, 0, 0);
    add_row(OP_REMOVE,  42, 0, 0,   0, 0, 0);
    add_row(OP_REMOVE, 127, 1, 0,   0, 0, 1);
    add_row(OP_REMOVE, 127, 1, 1,   0, 0, 1);
    add_row(OP_CREATE,   1, 1, 0,   1, 1, 0);
    add_row(OP_RAISE,    1, 1, 0,   1, 1, 0);
    add_row(OP_REMOVE,   1, 1, 0,   0, 0, 1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].opc, dir_rows[i].id, dir_rows[i].typed,
                               dir_rows[i].rsp);

    // Random part: grow the list, churn it, then drain it
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n < 350) begin
        p_create = 55; p_raise = 15; p_lower = 15;
      end else if (n < 650) begin
        p_create = 30; p_raise = 25; p_lower = 20;
      end else begin
        p_create = 15; p_raise = 15; p_lower = 15;
      end
      roll = $urandom_range(0, 99);
      if (roll < p_create) begin
        opc = OP_CREATE;
        id  = pick_id(20);
      end else begin
        if (roll < p_create + p_raise) opc = OP_RAISE;
        else if (roll < p_create + p_raise + p_lower) opc = OP_LOWER;
        else opc = OP_REMOVE;
        id = pick_id(85);
      end
      send(opc, id, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[window_stacking_order_list] OK");
    end else begin
      $display("[window_stacking_order_list] ERROR");
    end
    $finish;
  end

  // Response side: check each transaction, random stalls and one long hold-off
  int  hold_cnt = 0;
  bit  held     = 1'b0;

  always @(posedge clk) begin
    order_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      rsp_seen++;
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected response status=%0d front=%0d back=%0d empty=%0d",
                 $time, status, front_id, back_id, list_empty);
        errors++;
      end else begin
        want = rsp_q.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (front_id !== want.front) begin
          $display("%0t: front_id expected %0d actual %0d", $time, want.front, front_id);
          errors++;
        end
        if (back_id !== want.back) begin
          $display("%0t: back_id expected %0d actual %0d", $time, want.back, back_id);
          errors++;
        end
        if (list_empty !== want.empty) begin
          $display("%0t: list_empty expected %0d actual %0d", $time, want.empty, list_empty);
          errors++;
        end
      end
    end

    // stall pattern: long hold-off once, quiet stretch, else about 6 in 100
    if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (rsp_seen >= 200 && !held) begin
      held      <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (rsp_seen > 500 && rsp_seen < 700) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 6);
    end
  end

  // Watchdog
  initial begin
    #20ms;
    $display("[window_stacking_order_list] ERROR");
    $finish;
  end

endmodule
